// ----- hdl/slpg_pkg.sv -----
// Shared constants and types for the status LED pattern generator.
package slpg_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned IVAL_W   = 16;
	localparam int unsigned STEP_W   = 6;
	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned IN_W     = 40;
	localparam int unsigned OUT_W    = 16;
	localparam int unsigned CFG_IX_W = 3;

	// register indexes
	localparam logic [CFG_IX_W-1:0] REG_INIT_BLINK    = 3'd0;
	localparam logic [CFG_IX_W-1:0] REG_TAKEOFF_BLINK = 3'd1;
	localparam logic [CFG_IX_W-1:0] REG_HOVER_BLINK   = 3'd2;
	localparam logic [CFG_IX_W-1:0] REG_FAST_BLINK    = 3'd3;
	localparam logic [CFG_IX_W-1:0] REG_FLASH         = 3'd4;
	localparam logic [CFG_IX_W-1:0] REG_FADE_PERIOD   = 3'd5;
	localparam logic [CFG_IX_W-1:0] REG_FADE_STEP     = 3'd6;
	localparam logic [CFG_IX_W-1:0] REG_RECORD_BLINK  = 3'd7;

	// register reset values
	localparam logic [IVAL_W-1:0] RST_INIT_BLINK    = 16'd500;
	localparam logic [IVAL_W-1:0] RST_TAKEOFF_BLINK = 16'd200;
	localparam logic [IVAL_W-1:0] RST_HOVER_BLINK   = 16'd1000;
	localparam logic [IVAL_W-1:0] RST_FAST_BLINK    = 16'd100;
	localparam logic [IVAL_W-1:0] RST_FLASH         = 16'd100;
	localparam logic [IVAL_W-1:0] RST_FADE_PERIOD   = 16'd20;
	localparam logic [STEP_W-1:0] RST_FADE_STEP     = 6'd5;
	localparam logic [IVAL_W-1:0] RST_RECORD_BLINK  = 16'd1000;

	// vehicle states
	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_ARMED    = 3'd1;
	localparam logic [2:0] ST_DISARMED = 3'd2;
	localparam logic [2:0] ST_TAKEOFF  = 3'd3;
	localparam logic [2:0] ST_FLIGHT   = 3'd4;
	localparam logic [2:0] ST_FAILSAFE = 3'd5;
	localparam logic [2:0] ST_OBSTACLE = 3'd6;

	// flight modes
	localparam logic [1:0] FM_LEVEL = 2'd0;
	localparam logic [1:0] FM_HOLD  = 2'd1;
	localparam logic [1:0] FM_GLIDE = 2'd2;

	// breathing turn-around limits
	localparam logic signed [9:0] FADE_LOW   = 10'sd5;
	localparam logic signed [9:0] FADE_HIGH  = 10'sd250;
	localparam logic signed [9:0] DUTY_MAXS  = 10'sd255;

	typedef struct packed {
		logic              photo_taken;
		logic              is_recording;
		logic [1:0]        flight_mode;
		logic [2:0]        drone_state;
		logic [TIME_W-1:0] now_ms;
	} upd_t;

	typedef struct packed {
		logic [DUTY_W-1:0] pwm_duty;
		logic              pwm_attached;
		logic              rear_level;
		logic              front_level;
	} led_t;

	function automatic logic elapsed(input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] last, input logic [IVAL_W-1:0] iv);
		logic [TIME_W-1:0] diff;
		diff = now - last;
		return diff >= {{(TIME_W-IVAL_W){1'b0}}, iv};
	endfunction

endpackage

// ----- hdl/status_led_pattern_generator_unit.sv -----
// Status LED pattern generator: input register, pattern logic, result register.
// Path: an accepted update is held in the input register, and its result is loaded into the result register.
// Throughput: one update per cycle while the master side does not stall; the pattern state updates in one pass.
// The input register keeps taking updates while a result waits, until it is full.
// arst_n clears all pattern state and loads the default interval registers.
module status_led_pattern_generator_unit
	import slpg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// now_ms[31:0], drone_state[34:32], flight_mode[36:35], is_recording[37],
	// photo_taken[38], zero[39]
	input  logic [IN_W-1:0]     s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// front_level[0], rear_level[1], pwm_attached[2], pwm_duty[10:3], zero[15:11]
	output logic [OUT_W-1:0]    m_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [IVAL_W-1:0]   cfg_data
);

	logic [IVAL_W-1:0] init_blink_q, takeoff_blink_q, hover_blink_q, fast_blink_q;
	logic [IVAL_W-1:0] flash_q, fade_period_q, record_blink_q;
	logic [STEP_W-1:0] fade_step_q;

	logic              vld_s1;
	upd_t              upd_s1;
	logic              out_vld_q;
	led_t              out_q;
	logic              adv;

	logic [TIME_W-1:0] flash_start_q, blink_last_q, fade_last_q, record_last_q;
	logic              flash_run_q, blink_phase_q, fade_down_q, record_phase_q;
	logic              pwm_on_q, front_q, rear_q;
	logic [DUTY_W-1:0] duty_q;

	logic [TIME_W-1:0] flash_start_d, blink_last_d, fade_last_d, record_last_d;
	logic              flash_run_d, blink_phase_d, fade_down_d, record_phase_d;
	logic              pwm_on_d, front_d, rear_d;
	logic [DUTY_W-1:0] duty_d;

	logic              cruise, blink_en, blink_hit;
	logic [IVAL_W-1:0] blink_iv;
	logic signed [9:0] fsum;

	assign cfg_ready = 1'b1;
	assign adv       = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !vld_s1 || adv;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {{(OUT_W-DUTY_W-3){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_blink_q    <= RST_INIT_BLINK;
			takeoff_blink_q <= RST_TAKEOFF_BLINK;
			hover_blink_q   <= RST_HOVER_BLINK;
			fast_blink_q    <= RST_FAST_BLINK;
			flash_q         <= RST_FLASH;
			fade_period_q   <= RST_FADE_PERIOD;
			fade_step_q     <= RST_FADE_STEP;
			record_blink_q  <= RST_RECORD_BLINK;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INIT_BLINK:    init_blink_q    <= cfg_data;
				REG_TAKEOFF_BLINK: takeoff_blink_q <= cfg_data;
				REG_HOVER_BLINK:   hover_blink_q   <= cfg_data;
				REG_FAST_BLINK:    fast_blink_q    <= cfg_data;
				REG_FLASH:         flash_q         <= cfg_data;
				REG_FADE_PERIOD:   fade_period_q   <= cfg_data;
				REG_FADE_STEP:     fade_step_q     <= cfg_data[STEP_W-1:0];
				REG_RECORD_BLINK:  record_blink_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			upd_s1 <= upd_t'(s_tdata[IN_W-2:0]);
		end
	end

	// blink interval for the current state, if the state blinks at all
	always_comb begin
		blink_en = 1'b1;
		blink_iv = init_blink_q;
		case (upd_s1.drone_state)
			ST_INIT, ST_DISARMED: blink_iv = init_blink_q;
			ST_TAKEOFF:           blink_iv = takeoff_blink_q;
			ST_FAILSAFE, ST_OBSTACLE: blink_iv = fast_blink_q;
			ST_FLIGHT: begin
				blink_iv = hover_blink_q;
				blink_en = (upd_s1.flight_mode == FM_HOLD);
			end
			default: blink_en = 1'b0;
		endcase
		blink_hit = blink_en && elapsed(upd_s1.now_ms, blink_last_q, blink_iv);
	end

	always_comb begin
		flash_start_d  = flash_start_q;
		flash_run_d    = flash_run_q;
		blink_last_d   = blink_last_q;
		blink_phase_d  = blink_phase_q;
		fade_last_d    = fade_last_q;
		fade_down_d    = fade_down_q;
		duty_d         = duty_q;
		record_last_d  = record_last_q;
		record_phase_d = record_phase_q;
		pwm_on_d       = pwm_on_q;
		front_d        = front_q;
		rear_d         = rear_q;
		fsum           = '0;

		cruise = (upd_s1.drone_state == ST_FLIGHT) && (upd_s1.flight_mode == FM_GLIDE);

		if (upd_s1.photo_taken) begin
			front_d       = 1'b1;
			flash_start_d = upd_s1.now_ms;
			flash_run_d   = 1'b1;
		end
		if (flash_run_d && elapsed(upd_s1.now_ms, flash_start_d, flash_q)) begin
			front_d     = 1'b0;
			flash_run_d = 1'b0;
		end

		if (cruise && !pwm_on_q) begin
			pwm_on_d = 1'b1;
		end else if (!cruise && pwm_on_q) begin
			pwm_on_d = 1'b0;
			front_d  = 1'b0;
		end

		if (blink_hit) begin
			blink_phase_d = !blink_phase_q;
			blink_last_d  = upd_s1.now_ms;
		end

		case (upd_s1.drone_state)
			ST_INIT, ST_TAKEOFF, ST_OBSTACLE: begin
				if (blink_hit) begin
					front_d = blink_phase_d;
					rear_d  = blink_phase_d;
				end
			end
			ST_ARMED: begin
				front_d = 1'b1;
				rear_d  = 1'b1;
			end
			ST_DISARMED: begin
				if (blink_hit) begin
					front_d = blink_phase_d;
					rear_d  = 1'b0;
				end
			end
			ST_FAILSAFE: begin
				if (blink_hit) begin
					front_d = 1'b0;
					rear_d  = blink_phase_d;
				end
			end
			ST_FLIGHT: begin
				case (upd_s1.flight_mode)
					FM_LEVEL: begin
						front_d = 1'b1;
						rear_d  = 1'b0;
					end
					FM_HOLD: begin
						if (blink_hit) begin
							front_d = blink_phase_d;
							rear_d  = 1'b0;
						end
					end
					FM_GLIDE: begin
						rear_d = 1'b0;
						if (elapsed(upd_s1.now_ms, fade_last_q, fade_period_q)) begin
							if (fade_down_q)
								fsum = $signed({2'b00, duty_q}) - $signed({4'b0000, fade_step_q});
							else
								fsum = $signed({2'b00, duty_q}) + $signed({4'b0000, fade_step_q});
							if (fsum <= FADE_LOW || fsum >= FADE_HIGH)
								fade_down_d = !fade_down_q;
							// saturate to the 8-bit duty range
							if (fsum < 0)
								duty_d = '0;
							else if (fsum > DUTY_MAXS)
								duty_d = '1;
							else
								duty_d = fsum[DUTY_W-1:0];
							fade_last_d = upd_s1.now_ms;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// recording overrides in flight outside cruise
		if (upd_s1.is_recording && upd_s1.drone_state == ST_FLIGHT &&
				upd_s1.flight_mode != FM_GLIDE) begin
			rear_d = 1'b1;
			if (elapsed(upd_s1.now_ms, record_last_q, record_blink_q)) begin
				record_phase_d = !record_phase_q;
				front_d        = record_phase_d;
				record_last_d  = upd_s1.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_start_q  <= '0;
			flash_run_q    <= 1'b0;
			blink_last_q   <= '0;
			blink_phase_q  <= 1'b0;
			fade_last_q    <= '0;
			fade_down_q    <= 1'b0;
			duty_q         <= '0;
			record_last_q  <= '0;
			record_phase_q <= 1'b0;
			pwm_on_q       <= 1'b0;
			front_q        <= 1'b0;
			rear_q         <= 1'b0;
		end else if (adv) begin
			flash_start_q  <= flash_start_d;
			flash_run_q    <= flash_run_d;
			blink_last_q   <= blink_last_d;
			blink_phase_q  <= blink_phase_d;
			fade_last_q    <= fade_last_d;
			fade_down_q    <= fade_down_d;
			duty_q         <= duty_d;
			record_last_q  <= record_last_d;
			record_phase_q <= record_phase_d;
			pwm_on_q       <= pwm_on_d;
			front_q        <= front_d;
			rear_q         <= rear_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.front_level  <= front_d;
			out_q.rear_level   <= rear_d;
			out_q.pwm_attached <= pwm_on_d;
			out_q.pwm_duty     <= duty_d;
		end
	end

endmodule

// ----- test/status_led_pattern_generator_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the status LED pattern generator unit.
module status_led_pattern_generator_unit_test
	import slpg_pkg::*;
;

	localparam logic [2:0] ST_UNKNOWN   = 3'd7;
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int SHOW_LIMIT  = 10;

	// Tracks the LED pattern state and holds the LED words still to come.
	class led_pattern_tracker;
		logic [IVAL_W-1:0] init_iv, takeoff_iv, hover_iv, fast_iv;
		logic [IVAL_W-1:0] flash_iv, fade_iv, record_iv;
		logic [STEP_W-1:0] fade_step;
		logic [TIME_W-1:0] flash_t0, blink_t0, fade_t0, record_t0;
		logic [DUTY_W-1:0] duty;
		bit flash_on, blink_ph, ramp_down, record_ph, pwm_hold, front_q, rear_q;
		led_t led_queue[$];
		int fails;

		function new();
			init_iv    = RST_INIT_BLINK;
			takeoff_iv = RST_TAKEOFF_BLINK;
			hover_iv   = RST_HOVER_BLINK;
			fast_iv    = RST_FAST_BLINK;
			flash_iv   = RST_FLASH;
			fade_iv    = RST_FADE_PERIOD;
			fade_step  = RST_FADE_STEP;
			record_iv  = RST_RECORD_BLINK;
			flash_t0   = '0;
			blink_t0   = '0;
			fade_t0    = '0;
			record_t0  = '0;
			duty       = '0;
			flash_on   = 1'b0;
			blink_ph   = 1'b0;
			ramp_down  = 1'b0;
			record_ph  = 1'b0;
			pwm_hold   = 1'b0;
			front_q    = 1'b0;
			rear_q     = 1'b0;
			fails      = 0;
		endfunction

		function void set_register(input logic [CFG_IX_W-1:0] idx,
			input logic [IVAL_W-1:0] val);
			case (idx)
				REG_INIT_BLINK:    init_iv    = val;
				REG_TAKEOFF_BLINK: takeoff_iv = val;
				REG_HOVER_BLINK:   hover_iv   = val;
				REG_FAST_BLINK:    fast_iv    = val;
				REG_FLASH:         flash_iv   = val;
				REG_FADE_PERIOD:   fade_iv    = val;
				REG_FADE_STEP:     fade_step  = val[STEP_W-1:0];
				REG_RECORD_BLINK:  record_iv  = val;
				default: ;
			endcase
		endfunction

		// time differences wrap modulo 2^32
		function bit passed(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] last,
			input logic [IVAL_W-1:0] iv);
			logic [TIME_W-1:0] span;
			span = now - last;
			return span >= iv;
		endfunction

		function bit blink_step(input logic [TIME_W-1:0] now, input logic [IVAL_W-1:0] iv);
			if (!passed(now, blink_t0, iv))
				return 1'b0;
			blink_ph = !blink_ph;
			blink_t0 = now;
			return 1'b1;
		endfunction

		function void breathe_step(input logic [TIME_W-1:0] now);
			int sum;
			if (!passed(now, fade_t0, fade_iv))
				return;
			sum = ramp_down ? int'(duty) - int'(fade_step) : int'(duty) + int'(fade_step);
			if (sum <= int'(FADE_LOW) || sum >= int'(FADE_HIGH))
				ramp_down = !ramp_down;
			if (sum < 0)
				sum = 0;
			if (sum > int'(DUTY_MAXS))
				sum = int'(DUTY_MAXS);
			duty = sum[DUTY_W-1:0];
			fade_t0 = now;
		endfunction

		function void take_update(input upd_t u);
			bit cruise;
			led_t want;
			cruise = (u.drone_state == ST_FLIGHT) && (u.flight_mode == FM_GLIDE);
			if (u.photo_taken) begin
				front_q  = 1'b1;
				flash_t0 = u.now_ms;
				flash_on = 1'b1;
			end
			if (flash_on && passed(u.now_ms, flash_t0, flash_iv)) begin
				front_q  = 1'b0;
				flash_on = 1'b0;
			end
			if (cruise && !pwm_hold) begin
				pwm_hold = 1'b1;
			end else if (!cruise && pwm_hold) begin
				pwm_hold = 1'b0;
				front_q  = 1'b0;
			end
			case (u.drone_state)
				ST_INIT: begin
					if (blink_step(u.now_ms, init_iv)) begin
						front_q = blink_ph;
						rear_q  = blink_ph;
					end
				end
				ST_ARMED: begin
					front_q = 1'b1;
					rear_q  = 1'b1;
				end
				ST_DISARMED: begin
					if (blink_step(u.now_ms, init_iv)) begin
						front_q = blink_ph;
						rear_q  = 1'b0;
					end
				end
				ST_TAKEOFF: begin
					if (blink_step(u.now_ms, takeoff_iv)) begin
						front_q = blink_ph;
						rear_q  = blink_ph;
					end
				end
				ST_FLIGHT: begin
					if (u.flight_mode == FM_LEVEL) begin
						front_q = 1'b1;
						rear_q  = 1'b0;
					end else if (u.flight_mode == FM_HOLD) begin
						if (blink_step(u.now_ms, hover_iv)) begin
							front_q = blink_ph;
							rear_q  = 1'b0;
						end
					end else if (u.flight_mode == FM_GLIDE) begin
						breathe_step(u.now_ms);
						rear_q = 1'b0;
					end
				end
				ST_FAILSAFE: begin
					if (blink_step(u.now_ms, fast_iv)) begin
						front_q = 1'b0;
						rear_q  = blink_ph;
					end
				end
				ST_OBSTACLE: begin
					if (blink_step(u.now_ms, fast_iv)) begin
						front_q = blink_ph;
						rear_q  = blink_ph;
					end
				end
				default: ;
			endcase
			// recording overrides outside cruise, unknown modes included
			if (u.is_recording && u.drone_state == ST_FLIGHT && u.flight_mode != FM_GLIDE) begin
				rear_q = 1'b1;
				if (passed(u.now_ms, record_t0, record_iv)) begin
					record_ph = !record_ph;
					front_q   = record_ph;
					record_t0 = u.now_ms;
				end
			end
			want.front_level  = front_q;
			want.rear_level   = rear_q;
			want.pwm_attached = pwm_hold;
			want.pwm_duty     = duty;
			led_queue.push_back(want);
		endfunction

		function void check_leds(input logic [OUT_W-1:0] word);
			led_t got, want;
			got = word[$bits(led_t)-1:0];
			if (led_queue.size() == 0) begin
				fails++;
				if (fails <= SHOW_LIMIT)
					$display("%0t: LED transaction with no update pending: %h", $realtime, word);
				return;
			end
			want = led_queue.pop_front();
			if (got.front_level !== want.front_level || got.rear_level !== want.rear_level ||
				got.pwm_attached !== want.pwm_attached || got.pwm_duty !== want.pwm_duty ||
				word[OUT_W-1:$bits(led_t)] !== '0) begin
				fails++;
				if (fails <= SHOW_LIMIT)
					$display("%0t: LED mismatch: expected front %0b rear %0b pwm %0b duty %0d, %s",
						$realtime, want.front_level, want.rear_level, want.pwm_attached,
						want.pwm_duty, $sformatf("got front %0b rear %0b pwm %0b duty %0d pad %h",
						got.front_level, got.rear_level, got.pwm_attached, got.pwm_duty,
						word[OUT_W-1:$bits(led_t)]));
			end
		endfunction

		function int pending();
			return led_queue.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [IVAL_W-1:0]   cfg_data;

	led_pattern_tracker sb;
	logic [TIME_W-1:0] now_t;
	bit gaps_on;
	int hold_asks;
	int quiet_cycles;

	status_led_pattern_generator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.take_update(s_tdata[$bits(upd_t)-1:0]);
		if (m_tvalid && m_tready)
			sb.check_leds(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// result side: random stall bursts plus one long hold-off on request
	initial begin
		int hold_done;
		hold_done = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_asks != hold_done) begin
				hold_done = hold_asks;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	// starts and ends at a falling edge; tvalid stays high for the next caller
	task automatic send_update(input logic [TIME_W-1:0] now, input logic [2:0] st,
		input logic [1:0] mode, input bit rec, input bit photo);
		upd_t u;
		u.now_ms       = now;
		u.drone_state  = st;
		u.flight_mode  = mode;
		u.is_recording = rec;
		u.photo_taken  = photo;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{(IN_W-$bits(upd_t)){1'b0}}, u};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IX_W-1:0] idx,
		input logic [IVAL_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_registers(input int unsigned v_init, input int unsigned v_takeoff,
		input int unsigned v_hover, input int unsigned v_fast, input int unsigned v_flash,
		input int unsigned v_fade, input int unsigned v_step, input int unsigned v_record);
		// results all in, then time for the pipeline to drain
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_register(REG_INIT_BLINK,    v_init[IVAL_W-1:0]);
		write_register(REG_TAKEOFF_BLINK, v_takeoff[IVAL_W-1:0]);
		write_register(REG_HOVER_BLINK,   v_hover[IVAL_W-1:0]);
		write_register(REG_FAST_BLINK,    v_fast[IVAL_W-1:0]);
		write_register(REG_FLASH,         v_flash[IVAL_W-1:0]);
		write_register(REG_FADE_PERIOD,   v_fade[IVAL_W-1:0]);
		write_register(REG_FADE_STEP,     v_step[IVAL_W-1:0]);
		write_register(REG_RECORD_BLINK,  v_record[IVAL_W-1:0]);
	endtask

	// Runs of one state and mode with time moving forward, mixed with noise.
	task automatic run_phase(input int n_items, input int unsigned span);
		int left;
		int seg;
		int unsigned pick;
		logic [31:0] r;
		logic [2:0] st;
		logic [1:0] mode;
		bit rec_seg;
		bit rec;
		bit photo;
		left = n_items;
		while (left > 0) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				r = $urandom();
				send_update($urandom(), r[2:0], r[4:3], r[5], r[6]);
				if (r[7])
					now_t = $urandom();
				left--;
			end else begin
				r = $urandom();
				if (pick == 1) begin
					st   = r[2:0];
					mode = r[4:3];
				end else begin
					r[2:0] = (pick >= 6) ? ST_FLIGHT : 3'($urandom_range(0, 6));
					st   = r[2:0];
					mode = (r[4:3] == MODE_UNKNOWN && r[8]) ? FM_GLIDE : r[4:3];
				end
				rec_seg = r[5];
				seg = $urandom_range(3, 30);
				while (seg > 0 && left > 0) begin
					if ($urandom_range(0, 3) == 0)
						now_t = now_t + $urandom_range(0, 2);
					else
						now_t = now_t + $urandom_range(0, span);
					rec   = ($urandom_range(0, 7) == 0) ? !rec_seg : rec_seg;
					photo = ($urandom_range(0, 11) == 0);
					send_update(now_t, st, mode, rec, photo);
					seg--;
					left--;
				end
			end
		end
		s_tvalid = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		gaps_on   = 1'b1;
		hold_asks = 0;
		quiet_cycles = 0;
		now_t = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed pass on reset intervals
		send_update(32'd0,          ST_INIT,     FM_LEVEL,     1'b0, 1'b0);
		send_update(32'd0,          ST_ARMED,    FM_LEVEL,     1'b0, 1'b1); // flash at time zero
		send_update(32'd50,         ST_ARMED,    FM_LEVEL,     1'b0, 1'b0);
		send_update(32'd100,        ST_ARMED,    FM_LEVEL,     1'b0, 1'b0);
		send_update(32'd600,        ST_INIT,     FM_LEVEL,     1'b0, 1'b0);
		send_update(32'd1100,       ST_DISARMED, FM_HOLD,      1'b0, 1'b0);
		send_update(32'd1300,       ST_TAKEOFF,  FM_GLIDE,     1'b0, 1'b0);
		send_update(32'd1400,       ST_FLIGHT,   FM_LEVEL,     1'b0, 1'b0);
		send_update(32'd2400,       ST_FLIGHT,   FM_HOLD,      1'b0, 1'b0);
		send_update(32'd2420,       ST_FLIGHT,   FM_GLIDE,     1'b0, 1'b0);
		send_update(32'd2440,       ST_FLIGHT,   FM_GLIDE,     1'b0, 1'b0);
		send_update(32'd2460,       ST_FLIGHT,   FM_GLIDE,     1'b0, 1'b1);
		send_update(32'd2470,       ST_FLIGHT,   FM_LEVEL,     1'b1, 1'b0);
		send_update(32'd3470,       ST_FLIGHT,   FM_HOLD,      1'b1, 1'b0);
		send_update(32'd3480,       ST_FLIGHT,   MODE_UNKNOWN, 1'b1, 1'b0);
		send_update(32'd3600,       ST_FAILSAFE, FM_LEVEL,     1'b0, 1'b0);
		send_update(32'd3700,       ST_OBSTACLE, FM_HOLD,      1'b0, 1'b0);
		send_update(32'd3800,       ST_UNKNOWN,  MODE_UNKNOWN, 1'b1, 1'b1);
		send_update(32'hFFFF_FFF0,  ST_OBSTACLE, FM_LEVEL,     1'b0, 1'b0);
		send_update(32'hFFFF_FFFF,  ST_FAILSAFE, FM_LEVEL,     1'b0, 1'b1);
		send_update(32'h0000_0050,  ST_FAILSAFE, FM_LEVEL,     1'b0, 1'b0); // across the wrap
		send_update(32'h0000_0070,  ST_ARMED,    FM_LEVEL,     1'b0, 1'b0);
		send_update(32'h7FFF_FFFF,  ST_INIT,     FM_LEVEL,     1'b1, 1'b1);
		send_update(32'h8000_0000,  ST_FLIGHT,   FM_GLIDE,     1'b1, 1'b0);
		send_update(32'h8000_0000,  ST_FLIGHT,   FM_GLIDE,     1'b0, 1'b0);
		s_tvalid = 1'b0;
		now_t = 32'h8000_0000;

		// short intervals, with one long hold-off on the result side
		load_registers($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
			$urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
			$urandom_range(1, 50), $urandom_range(1, 40));
		hold_asks++;
		run_phase(80, 60);

		load_registers(1, 1, 1, 1, 1, 1, 50, 1);
		run_phase(80, 4);

		// zero intervals act on every update
		gaps_on = 1'b0;
		load_registers(0, 0, 0, 0, 0, 0, 50, 0);
		run_phase(80, 3);

		gaps_on = 1'b1;
		load_registers(65535, 65535, 65535, 65535, 65535, 65535, 1, 65535);
		hold_asks++;
		run_phase(80, 140000);

		load_registers($urandom_range(1, 2000), $urandom_range(1, 2000),
			$urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(1, 2000),
			$urandom_range(1, 2000), $urandom_range(1, 50), $urandom_range(1, 2000));
		run_phase(80, 2500);

		gaps_on = 1'b0;
		load_registers(RST_INIT_BLINK, RST_TAKEOFF_BLINK, RST_HOVER_BLINK, RST_FAST_BLINK,
			RST_FLASH, RST_FADE_PERIOD, RST_FADE_STEP, RST_RECORD_BLINK);
		run_phase(80, 1500);

		while (sb.pending() != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (sb.fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
